[design/wcc_pkg.sv]
// Package for the window cluster centroid block: field widths, register
// map and address constants. Depends on nothing.
`timescale 1ns / 1ps

package wcc_pkg;

	localparam int POS_W   = 31;
	localparam int DEP_W   = 16;
	localparam int TOT_W   = 32;
	localparam int WIN_W   = 16;
	localparam int OFF_W   = 16;
	localparam int QUO_W   = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd100;

	typedef enum logic {
		REG_WINDOW = 1'b0
	} reg_index_t;

endpackage

[design/wcc_if.sv]
// Stream interfaces for site items in and cluster items out.
// Depends on wcc_pkg for the field widths.
`timescale 1ns / 1ps

interface wcc_site_if;
	logic                      valid;
	logic                      ready;
	logic [wcc_pkg::POS_W-1:0] position;
	logic [wcc_pkg::DEP_W-1:0] depth;
	logic                      final_site;

	modport source (output valid, output position, output depth, output final_site,
		input ready);
	modport sink (input valid, input position, input depth, input final_site,
		output ready);
endinterface

interface wcc_result_if;
	logic                      valid;
	logic                      ready;
	logic [wcc_pkg::POS_W-1:0] center;
	logic [wcc_pkg::TOT_W-1:0] depth_sum;
	logic                      overflow_seen;
	logic                      last_result;

	modport source (output valid, output center, output depth_sum,
		output overflow_seen, output last_result, input ready);
	modport sink (input valid, input center, input depth_sum,
		input overflow_seen, input last_result, output ready);
endinterface

[design/wcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module wcc_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/window_cluster_centroid_top.sv]
// Top level of the window cluster centroid block: sequencer, site buffer,
// serial divider and output register. Depends on wcc_pkg, wcc_if and wcc_ram.
`timescale 1ns / 1ps

// Sites arrive in ascending position order; a repeated position adds its depth to
// the newest buffered entry. A site that closes a cluster walks the buffer through
// the one RAM read port, one entry a cycle, then runs a 16-step restoring divider
// for the rounded centre and its bookkeeping (the divider is skipped for a cluster
// of zero depth), plus one RAM read and compare per further old entry dropped
// from the window. A final site costs one more walk and divide. The next site is
// taken only once the sequencer is back in idle; a waiting result does not block
// that, but a result that must be sent while the output register is still full
// holds the sequencer. The buffer has no reset clearing; it needs no clearing pass.
module window_cluster_centroid_top #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wcc_pkg::APB_AW-1:0]  paddr,
	input  logic [wcc_pkg::APB_DW-1:0]  pwdata,
	output logic [wcc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	wcc_site_if.sink                    site,
	wcc_result_if.source                result
);

	localparam int IDX_W  = $clog2(BUFFER_DEPTH);
	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int SUM_W  = IDX_W + 2;
	localparam int ENT_W  = wcc_pkg::POS_W + wcc_pkg::TOT_W;
	localparam int PRD_W  = wcc_pkg::OFF_W + wcc_pkg::TOT_W;
	localparam int WSUM_W = wcc_pkg::TOT_W + CNT_W;
	localparam int SSUM_W = PRD_W + CNT_W;
	localparam int REM_W  = SSUM_W + 2;
	localparam int DCNT_W = $clog2(wcc_pkg::QUO_W);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_WALK, S_DIV_SET, S_DIV, S_CENT, S_OFFER,
		S_DROP, S_DROP_WAIT, S_APPEND, S_OVF_WAIT, S_FIN_CHK, S_FINAL
	} state_t;

	typedef enum logic {
		RET_DROP, RET_FIN
	} ret_t;

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] k);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(k);
		if (sum >= SUM_W'(BUFFER_DEPTH)) begin
			sum = sum - SUM_W'(BUFFER_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic beyond(input logic [wcc_pkg::POS_W-1:0] later,
		input logic [wcc_pkg::POS_W-1:0] earlier, input logic [wcc_pkg::WIN_W-1:0] win);
		logic [wcc_pkg::POS_W-1:0] diff;
		diff = later - earlier;
		return (later > earlier) && (diff > wcc_pkg::POS_W'(win));
	endfunction

	state_t                    state_q;
	ret_t                      ret_q;
	logic [wcc_pkg::WIN_W-1:0] window_q;

	logic [wcc_pkg::POS_W-1:0] p_q;
	logic [wcc_pkg::DEP_W-1:0] d_q;
	logic                      fin_q;

	logic [IDX_W-1:0]          oldest_idx_q;
	logic [IDX_W-1:0]          newest_idx_q;
	logic [CNT_W-1:0]          count_q;
	logic [wcc_pkg::POS_W-1:0] oldest_pos_q;
	logic [wcc_pkg::POS_W-1:0] newest_pos_q;
	logic [wcc_pkg::TOT_W-1:0] newest_dep_q;

	logic [CNT_W-1:0]          k_q;
	logic                      rv_s1;
	logic                      mv_s2;
	logic                      pv_s3;
	logic [wcc_pkg::OFF_W-1:0] off_s2;
	logic [wcc_pkg::TOT_W-1:0] dep_s2;
	logic [PRD_W-1:0]          prod_s3;
	logic [wcc_pkg::TOT_W-1:0] dep_s3;
	logic [WSUM_W-1:0]         w_acc_q;
	logic [SSUM_W-1:0]         s_acc_q;

	logic [REM_W-1:0]          rem_q;
	logic [REM_W-1:0]          dsh_q;
	logic [wcc_pkg::QUO_W-1:0] quo_q;
	logic [DCNT_W-1:0]         dcnt_q;

	logic [wcc_pkg::POS_W-1:0] c_q;
	logic [wcc_pkg::TOT_W-1:0] t_q;
	logic [wcc_pkg::POS_W-1:0] pend_c_q;
	logic [wcc_pkg::TOT_W-1:0] pend_t_q;
	logic                      pend_v_q;
	logic                      sticky_q;

	logic                      out_v_q;
	logic [wcc_pkg::POS_W-1:0] out_c_q;
	logic [wcc_pkg::TOT_W-1:0] out_t_q;
	logic                      out_ovf_q;
	logic                      out_last_q;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [ENT_W-1:0]          ram_wdata;
	logic                      ram_re;
	logic [IDX_W-1:0]          ram_raddr;
	logic [ENT_W-1:0]          ram_rdata;
	logic [wcc_pkg::POS_W-1:0] rd_pos;
	logic [wcc_pkg::TOT_W-1:0] rd_dep;

	logic                      rd_walk;
	logic                      out_free;
	logic                      out_load;
	logic                      cfg_wr;
	logic                      merge;
	logic [wcc_pkg::TOT_W:0]   merge_sum;
	logic [wcc_pkg::TOT_W-1:0] merge_dep;
	logic [wcc_pkg::POS_W-1:0] off_diff;
	logic [wcc_pkg::OFF_W-1:0] off_clamp;
	logic                      div_ge;
	logic [wcc_pkg::POS_W:0]   centre_sum;

	wcc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_pos    = ram_rdata[ENT_W-1:wcc_pkg::TOT_W];
	assign rd_dep    = ram_rdata[wcc_pkg::TOT_W-1:0];
	assign rd_walk   = (state_q == S_WALK) && (k_q != count_q);
	assign out_free  = !out_v_q || result.ready;
	assign out_load  = ((state_q == S_OFFER) && pend_v_q && (pend_c_q != c_q) && out_free) ||
		((state_q == S_FINAL) && out_free);
	assign cfg_wr    = psel && penable && pwrite;
	assign merge     = (count_q != '0) && (newest_pos_q == p_q);
	assign merge_sum = {1'b0, newest_dep_q} + (wcc_pkg::TOT_W + 1)'(d_q);
	assign merge_dep = merge_sum[wcc_pkg::TOT_W] ? '1 : merge_sum[wcc_pkg::TOT_W-1:0];
	assign off_diff  = (rd_pos > oldest_pos_q) ? (rd_pos - oldest_pos_q) : '0;
	assign off_clamp = (off_diff > wcc_pkg::POS_W'({wcc_pkg::OFF_W{1'b1}})) ? '1 :
		off_diff[wcc_pkg::OFF_W-1:0];
	assign div_ge    = rem_q >= dsh_q;
	assign centre_sum = {1'b0, oldest_pos_q} + (wcc_pkg::POS_W + 1)'(quo_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = newest_idx_q;
		ram_wdata = {p_q, newest_dep_q};
		ram_re    = 1'b0;
		ram_raddr = slot_of(oldest_idx_q, CNT_W'(1));
		case (state_q)
			S_DECIDE: begin
				if (merge) begin
					ram_we    = 1'b1;
					ram_wdata = {p_q, merge_dep};
				end
			end
			S_APPEND: begin
				if (count_q == CNT_W'(BUFFER_DEPTH)) begin
					ram_re = 1'b1;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = slot_of(oldest_idx_q, count_q);
					ram_wdata = {p_q, wcc_pkg::TOT_W'(d_q)};
				end
			end
			S_DROP: begin
				ram_re = count_q != CNT_W'(1);
			end
			S_WALK: begin
				ram_re    = rd_walk;
				ram_raddr = slot_of(oldest_idx_q, k_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= RET_DROP;
			window_q     <= wcc_pkg::WINDOW_RESET;
			oldest_idx_q <= '0;
			count_q      <= '0;
			pend_v_q     <= 1'b0;
			sticky_q     <= 1'b0;
			out_v_q      <= 1'b0;
			rv_s1        <= 1'b0;
			mv_s2        <= 1'b0;
			pv_s3        <= 1'b0;
		end else begin
			if (cfg_wr && (wcc_pkg::reg_index_t'(paddr[2]) == wcc_pkg::REG_WINDOW)) begin
				window_q <= pwdata[wcc_pkg::WIN_W-1:0];
			end

			if (result.ready && !out_load) begin
				out_v_q <= 1'b0;
			end

			rv_s1   <= rd_walk;
			mv_s2   <= rv_s1;
			pv_s3   <= mv_s2;
			off_s2  <= off_clamp;
			dep_s2  <= rd_dep;
			prod_s3 <= PRD_W'(off_s2) * PRD_W'(dep_s2);
			dep_s3  <= dep_s2;
			if (pv_s3) begin
				w_acc_q <= w_acc_q + WSUM_W'(dep_s3);
				s_acc_q <= s_acc_q + SSUM_W'(prod_s3);
			end

			case (state_q)
				S_IDLE: begin
					if (site.valid) begin
						p_q     <= site.position;
						d_q     <= site.depth;
						fin_q   <= site.final_site;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (merge) begin
						newest_dep_q <= merge_dep;
						state_q      <= S_FIN_CHK;
					end else if ((count_q != '0) && beyond(p_q, oldest_pos_q, window_q)) begin
						ret_q   <= RET_DROP;
						k_q     <= '0;
						w_acc_q <= '0;
						s_acc_q <= '0;
						state_q <= S_WALK;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_WALK: begin
					if (rd_walk) begin
						k_q <= k_q + CNT_W'(1);
					end else if (!rv_s1 && !mv_s2 && !pv_s3) begin
						state_q <= S_DIV_SET;
					end
				end
				S_DIV_SET: begin
					if (w_acc_q == '0) begin
						c_q     <= oldest_pos_q;
						t_q     <= '0;
						state_q <= S_OFFER;
					end else begin
						rem_q   <= REM_W'({s_acc_q, 1'b0}) + REM_W'(w_acc_q);
						dsh_q   <= REM_W'({w_acc_q, {wcc_pkg::QUO_W{1'b0}}});
						quo_q   <= '0;
						dcnt_q  <= DCNT_W'(wcc_pkg::QUO_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q <= {quo_q[wcc_pkg::QUO_W-2:0], div_ge};
					dsh_q <= dsh_q >> 1;
					if (dcnt_q == '0) begin
						state_q <= S_CENT;
					end else begin
						dcnt_q <= dcnt_q - DCNT_W'(1);
					end
				end
				S_CENT: begin
					c_q <= centre_sum[wcc_pkg::POS_W] ? '1 : centre_sum[wcc_pkg::POS_W-1:0];
					t_q <= (w_acc_q[WSUM_W-1:wcc_pkg::TOT_W] != '0) ? '1 :
						w_acc_q[wcc_pkg::TOT_W-1:0];
					state_q <= S_OFFER;
				end
				S_OFFER: begin
					if (!pend_v_q || (pend_c_q == c_q) || out_free) begin
						if (pend_v_q && (pend_c_q != c_q)) begin
							out_v_q    <= 1'b1;
							out_c_q    <= pend_c_q;
							out_t_q    <= pend_t_q;
							out_ovf_q  <= sticky_q;
							out_last_q <= 1'b0;
							sticky_q   <= 1'b0;
						end
						pend_c_q <= c_q;
						pend_t_q <= t_q;
						pend_v_q <= 1'b1;
						state_q  <= (ret_q == RET_FIN) ? S_FINAL : S_DROP;
					end
				end
				S_DROP: begin
					oldest_idx_q <= slot_of(oldest_idx_q, CNT_W'(1));
					count_q      <= count_q - CNT_W'(1);
					state_q      <= (count_q != CNT_W'(1)) ? S_DROP_WAIT : S_APPEND;
				end
				S_DROP_WAIT: begin
					oldest_pos_q <= rd_pos;
					state_q      <= beyond(p_q, rd_pos, window_q) ? S_DROP : S_APPEND;
				end
				S_APPEND: begin
					if (count_q == CNT_W'(BUFFER_DEPTH)) begin
						oldest_idx_q <= slot_of(oldest_idx_q, CNT_W'(1));
						count_q      <= CNT_W'(BUFFER_DEPTH - 1);
						sticky_q     <= 1'b1;
						state_q      <= S_OVF_WAIT;
					end else begin
						if (count_q == '0) begin
							oldest_pos_q <= p_q;
						end
						newest_idx_q <= slot_of(oldest_idx_q, count_q);
						newest_pos_q <= p_q;
						newest_dep_q <= wcc_pkg::TOT_W'(d_q);
						count_q      <= count_q + CNT_W'(1);
						state_q      <= S_FIN_CHK;
					end
				end
				S_OVF_WAIT: begin
					oldest_pos_q <= rd_pos;
					state_q      <= S_APPEND;
				end
				S_FIN_CHK: begin
					if (fin_q) begin
						ret_q   <= RET_FIN;
						k_q     <= '0;
						w_acc_q <= '0;
						s_acc_q <= '0;
						state_q <= S_WALK;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_v_q      <= 1'b1;
						out_c_q      <= pend_c_q;
						out_t_q      <= pend_t_q;
						out_ovf_q    <= sticky_q;
						out_last_q   <= 1'b1;
						sticky_q     <= 1'b0;
						pend_v_q     <= 1'b0;
						count_q      <= '0;
						oldest_idx_q <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign site.ready           = state_q == S_IDLE;
	assign result.valid         = out_v_q;
	assign result.center        = out_c_q;
	assign result.depth_sum     = out_t_q;
	assign result.overflow_seen = out_ovf_q;
	assign result.last_result   = out_last_q;

	assign pready = 1'b1;
	assign prdata = (wcc_pkg::reg_index_t'(paddr[2]) == wcc_pkg::REG_WINDOW) ?
		wcc_pkg::APB_DW'(window_q) : '0;

endmodule
